// ----- src/iwt_pkg.sv -----
package iwt_pkg;

    localparam int MaxTargets = 16;
    localparam int IdxW = $clog2(MaxTargets);
    localparam int SizeW = $clog2(MaxTargets + 1);
    localparam int EdgeW = 16;
    localparam int BoxW = 4 * EdgeW;

    typedef enum logic [1:0] {
        MODE_BOX   = 2'd0,
        MODE_FRAME = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    localparam logic [1:0] CFG_CONF    = 2'd0;
    localparam logic [1:0] CFG_PERSIST = 2'd1;
    localparam logic [1:0] CFG_OVERLAP = 2'd2;

    // start/result signals between sequencer and iou unit
    typedef struct packed {
        logic            start;
        logic [BoxW-1:0] box_a;
        logic [BoxW-1:0] box_b;
        logic [8:0]      limit;
    } t_iou_req;

    typedef struct packed {
        logic done;
        logic hit;
    } t_iou_rsp;

endpackage

// ----- src/iou_weak_target_tracker.sv -----
// low-confidence target tracker: boxes arrive one per transfer, a frame-end
// transfer closes each frame and yields the single result (model choice,
// carried target count, overflow flag). each tracked box is checked against
// the previous frame's targets one entry at a time through a shared iou unit.
// an entry is one launch state followed by the iou unit's edge, multiply,
// sum and compare steps, and the search stops at the first match. a frame
// end waits for any earlier result to leave; reset and ignored items go
// back to idle straight from decode.
// the two target tables are ping-pong banks, so a frame end outside heavy
// mode swaps by a pointer flip. once the heavy model is engaged, boxes are
// ignored and frame ends report the heavy model until a reset item (mode 2)
// clears the selector.
module iou_weak_target_tracker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_left_edge,
    input  logic [15:0] i_top_edge,
    input  logic [15:0] i_right_edge,
    input  logic [15:0] i_bottom_edge,
    input  logic signed [7:0] i_score,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_model_choice,
    output logic [4:0]  o_tracked_count,
    output logic        o_table_overflow,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_LOOKUP, S_WAIT, S_STORE, S_OUT
    } t_state;

    t_state r_state;

    // configuration
    logic [6:0] r_conf_lim;
    logic [7:0] r_persist;
    logic [8:0] r_overlap;

    // ping-pong target tables: bank r_bank is the previous frame
    logic [iwt_pkg::BoxW-1:0] r_box  [2][iwt_pkg::MaxTargets];
    logic [7:0]               r_cnt  [2][iwt_pkg::MaxTargets];
    logic                     r_bank;
    logic [iwt_pkg::SizeW-1:0] r_old_size, r_new_size, r_idx;
    logic r_pending, r_ovf_seen, r_sel;

    // captured item
    logic [1:0]               r_mode;
    logic [iwt_pkg::BoxW-1:0] r_in_box;
    logic signed [7:0]        r_score;
    logic [7:0]               r_count;

    // result
    logic       r_out_valid, r_out_model, r_out_ovf;
    logic [4:0] r_out_count;

    iwt_pkg::t_iou_req w_req;
    iwt_pkg::t_iou_rsp w_rsp;
    logic [7:0] w_match_cnt;

    assign w_match_cnt = (r_cnt[r_bank][r_idx[iwt_pkg::IdxW-1:0]] == 8'hFF) ? 8'hFF
                       : r_cnt[r_bank][r_idx[iwt_pkg::IdxW-1:0]] + 8'd1;

    assign w_req.start = (r_state == S_LOOKUP);
    assign w_req.box_a = r_in_box;
    assign w_req.box_b = r_box[r_bank][r_idx[iwt_pkg::IdxW-1:0]];
    assign w_req.limit = r_overlap;

    iwt_iou_unit u_iou (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);

    // configuration writes, other indices ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conf_lim <= 7'd50;
            r_persist  <= 8'd5;
            r_overlap  <= 9'd128;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                iwt_pkg::CFG_CONF:    r_conf_lim <= i_cfg_data[6:0];
                iwt_pkg::CFG_PERSIST: r_persist  <= i_cfg_data[7:0];
                iwt_pkg::CFG_OVERLAP: r_overlap  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // table writes
    always_ff @(posedge i_clk) begin
        if (r_state == S_STORE && r_new_size < iwt_pkg::SizeW'(iwt_pkg::MaxTargets)) begin
            r_box[~r_bank][r_new_size[iwt_pkg::IdxW-1:0]] <= r_in_box;
            r_cnt[~r_bank][r_new_size[iwt_pkg::IdxW-1:0]] <= r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bank      <= 1'b0;
            r_old_size  <= '0;
            r_new_size  <= '0;
            r_idx       <= '0;
            r_pending   <= 1'b0;
            r_ovf_seen  <= 1'b0;
            r_sel       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_mode   <= i_mode;
                        r_in_box <= {i_bottom_edge, i_right_edge, i_top_edge, i_left_edge};
                        r_score  <= i_score;
                        r_state  <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_idx   <= '0;
                    r_count <= 8'd1;
                    unique case (r_mode)
                        iwt_pkg::MODE_BOX: begin
                            if (r_sel || r_score == -8'sd1
                                    || r_score > signed'({1'b0, r_conf_lim}))
                                r_state <= S_IDLE;
                            else if (r_old_size == '0)
                                r_state <= S_STORE;
                            else
                                r_state <= S_LOOKUP;
                        end
                        iwt_pkg::MODE_FRAME: begin
                            // wait for any earlier result to drain
                            if (!r_out_valid || !i_stall) r_state <= S_OUT;
                        end
                        iwt_pkg::MODE_CLEAR: begin
                            r_sel      <= 1'b0;
                            r_old_size <= '0;
                            r_new_size <= '0;
                            r_pending  <= 1'b0;
                            r_ovf_seen <= 1'b0;
                            r_state    <= S_IDLE;
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_LOOKUP: r_state <= S_WAIT;
                S_WAIT: begin
                    if (w_rsp.done) begin
                        if (w_rsp.hit) begin
                            r_count <= w_match_cnt;
                            if (w_match_cnt >= r_persist) r_pending <= 1'b1;
                            r_state <= S_STORE;
                        end else if (r_idx + 1'b1 >= r_old_size) begin
                            r_state <= S_STORE;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_LOOKUP;
                        end
                    end
                end
                S_STORE: begin
                    if (r_new_size < iwt_pkg::SizeW'(iwt_pkg::MaxTargets))
                        r_new_size <= r_new_size + 1'b1;
                    else
                        r_ovf_seen <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_OUT: begin
                    r_out_valid <= 1'b1;
                    if (!r_sel) begin
                        r_bank    <= ~r_bank;
                        r_out_ovf <= r_ovf_seen;
                        if (r_pending) begin
                            r_sel       <= 1'b1;
                            r_old_size  <= '0;
                            r_out_model <= 1'b1;
                            r_out_count <= '0;
                        end else begin
                            r_old_size  <= r_new_size;
                            r_out_model <= 1'b0;
                            r_out_count <= 5'(r_new_size);
                        end
                    end else begin
                        r_out_ovf   <= 1'b0;
                        r_out_model <= 1'b1;
                        r_out_count <= '0;
                    end
                    r_new_size <= '0;
                    r_pending  <= 1'b0;
                    r_ovf_seen <= 1'b0;
                    r_state    <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid          = r_out_valid;
    assign o_model_choice   = r_out_model;
    assign o_tracked_count  = r_out_count;
    assign o_table_overflow = r_out_ovf;

endmodule

// ----- src/iwt_iou_unit.sv -----
module iwt_iou_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  iwt_pkg::t_iou_req  i_req,
    output iwt_pkg::t_iou_rsp  o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE, S_EDGE, S_MUL1, S_MUL2, S_SUM, S_CMP1, S_CMP2
    } t_state;

    t_state r_state;
    logic signed [17:0] r_w, r_h, r_aw, r_ah, r_bw, r_bh;
    logic               r_ovl;
    logic signed [36:0] r_inter, r_area_a, r_area_b, r_uni;
    logic signed [46:0] r_lhs, r_rhs;
    logic [8:0]         r_limit;
    logic               r_done, r_hit;

    logic signed [17:0] n_xl, n_yt, n_xr, n_yb;
    logic [15:0] a0, a1, a2, a3, b0, b1, b2, b3;

    assign {a3, a2, a1, a0} = i_req.box_a;
    assign {b3, b2, b1, b0} = i_req.box_b;

    always_comb begin
        n_xl = signed'({2'b00, (a0 > b0) ? a0 : b0});
        n_yt = signed'({2'b00, (a1 > b1) ? a1 : b1});
        n_xr = signed'({2'b00, (a2 < b2) ? a2 : b2});
        n_yb = signed'({2'b00, (a3 < b3) ? a3 : b3});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_w     <= n_xr - n_xl;
                        r_h     <= n_yb - n_yt;
                        r_ovl   <= (n_xr >= n_xl) && (n_yb >= n_yt);
                        r_aw    <= signed'({2'b00, a2}) - signed'({2'b00, a0});
                        r_ah    <= signed'({2'b00, a3}) - signed'({2'b00, a1});
                        r_bw    <= signed'({2'b00, b2}) - signed'({2'b00, b0});
                        r_bh    <= signed'({2'b00, b3}) - signed'({2'b00, b1});
                        r_limit <= i_req.limit;
                        r_state <= S_EDGE;
                    end
                end
                S_EDGE: begin
                    r_inter <= r_ovl ? 37'(r_w * r_h) : '0;
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_area_a <= 37'(r_aw * r_ah);
                    r_state  <= S_MUL2;
                end
                S_MUL2: begin
                    r_area_b <= 37'(r_bw * r_bh);
                    r_state  <= S_SUM;
                end
                S_SUM: begin
                    r_uni   <= r_area_a + r_area_b - r_inter;
                    r_state <= S_CMP1;
                end
                S_CMP1: begin
                    r_lhs   <= 47'(r_inter) <<< 8;
                    r_rhs   <= 47'(signed'({1'b0, r_limit}) * r_uni);
                    r_state <= S_CMP2;
                end
                S_CMP2: begin
                    r_hit   <= (r_uni > 37'sd0) && (r_lhs >= r_rhs);
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.hit  = r_hit;

endmodule

// ----- tb/tb_iou_weak_target_tracker.sv -----
`timescale 1ns / 100ps

// scoreboard: mirrors the tracker state and queues the frame-end results
class tracker_scoreboard;
    logic [6:0]  conf_lim;
    logic [7:0]  persist_lim;
    logic [8:0]  overlap_lim;
    logic [63:0] prev_box [16];
    int          prev_cnt [16];
    logic [63:0] next_box [16];
    int          next_cnt [16];
    int          prev_size;
    int          next_size;
    bit          switch_due;
    bit          dropped;
    bit          heavy;
    logic [6:0]  frame_results [$];
    int          mismatches;

    function new();
        conf_lim = 50;
        persist_lim = 5;
        overlap_lim = 128;
        prev_size = 0;
        next_size = 0;
        switch_due = 0;
        dropped = 0;
        heavy = 0;
        mismatches = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [8:0] val);
        case (idx)
            iwt_pkg::CFG_CONF:    conf_lim = val[6:0];
            iwt_pkg::CFG_PERSIST: persist_lim = val[7:0];
            iwt_pkg::CFG_OVERLAP: overlap_lim = val;
            default: ;
        endcase
    endfunction

    // overlap test without division, signed widths as the edges give them
    function bit overlaps(logic [63:0] a, logic [63:0] b);
        longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
        longint xl, yt, xr, yb, inter, uni;
        ax0 = a[15:0];  ay0 = a[31:16]; ax1 = a[47:32]; ay1 = a[63:48];
        bx0 = b[15:0];  by0 = b[31:16]; bx1 = b[47:32]; by1 = b[63:48];
        xl = ax0 > bx0 ? ax0 : bx0;
        yt = ay0 > by0 ? ay0 : by0;
        xr = ax1 < bx1 ? ax1 : bx1;
        yb = ay1 < by1 ? ay1 : by1;
        inter = 0;
        if (xr >= xl && yb >= yt) inter = (xr - xl) * (yb - yt);
        uni = (ax1 - ax0) * (ay1 - ay0) + (bx1 - bx0) * (by1 - by0) - inter;
        if (uni <= 0) return 0;
        return inter * 256 >= longint'(overlap_lim) * uni;
    endfunction

    // note one accepted input transfer
    function void note_input(iwt_pkg::t_mode m, logic [63:0] box, logic signed [7:0] s);
        int cnt;
        case (m)
            iwt_pkg::MODE_BOX: begin
                if (heavy || s == -1 || int'(s) > int'(conf_lim)) return;
                cnt = 1;
                for (int i = 0; i < prev_size; i++) begin
                    if (overlaps(box, prev_box[i])) begin
                        cnt = prev_cnt[i] + 1;
                        if (cnt > 255) cnt = 255;
                        if (cnt >= persist_lim) switch_due = 1;
                        break;
                    end
                end
                if (next_size < 16) begin
                    next_box[next_size] = box;
                    next_cnt[next_size] = cnt;
                    next_size++;
                end else begin
                    dropped = 1;
                end
            end
            iwt_pkg::MODE_FRAME: begin
                bit ovf;
                logic [6:0] exp_r;
                ovf = 0;
                if (!heavy) begin
                    prev_box = next_box;
                    prev_cnt = next_cnt;
                    prev_size = next_size;
                    ovf = dropped;
                    if (switch_due) begin
                        heavy = 1;
                        prev_size = 0;
                    end
                end
                next_size = 0;
                switch_due = 0;
                dropped = 0;
                exp_r = {heavy, heavy ? 5'd0 : 5'(prev_size), ovf};
                frame_results.insert(frame_results.size(), exp_r);
            end
            iwt_pkg::MODE_CLEAR: begin
                heavy = 0;
                prev_size = 0;
                next_size = 0;
                switch_due = 0;
                dropped = 0;
            end
            default: ;
        endcase
    endfunction

    // check one result transfer against the oldest expectation
    function void check_result(logic mc, logic [4:0] tc, logic ov);
        logic [6:0] exp_r;
        if (frame_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %0d %0d %0d", mc, tc, ov);
            return;
        end
        exp_r = frame_results.pop_front();
        if ({mc, tc, ov} !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result mismatch: exp choice %0d count %0d ovf %0d, got %0d %0d %0d",
                         exp_r[6], exp_r[5:1], exp_r[0], mc, tc, ov);
        end
    endfunction
endclass

module tb_iou_weak_target_tracker;

    // index outside the register list, writes to it are ignored
    localparam logic [1:0] CfgUnused = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_mode;
    logic [15:0] i_left_edge;
    logic [15:0] i_top_edge;
    logic [15:0] i_right_edge;
    logic [15:0] i_bottom_edge;
    logic signed [7:0] i_score;
    logic        o_valid;
    logic        i_stall;
    logic        o_model_choice;
    logic [4:0]  o_tracked_count;
    logic        o_table_overflow;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [8:0]  i_cfg_data;

    tracker_scoreboard sb;
    bit quiet;       // no idling in the closing stretch
    logic [63:0] cur_box;   // box of the previous frame, reused for matches

    iou_weak_target_tracker dut (.*);

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog, far above the slowest run including stalls
    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

    // result side: random stall bursts, check every result transfer
    initial begin
        int n;
        i_stall = 0;
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 6);
                i_stall <= 1;
                repeat (n) @(negedge i_clk);
                i_stall <= 0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_model_choice, o_tracked_count, o_table_overflow);
    end

    // one input transfer, valid held until accepted
    task automatic send_item(iwt_pkg::t_mode m, logic [63:0] box, logic signed [7:0] s);
        int n;
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 6);
            repeat (n) @(negedge i_clk);
        end
        i_valid <= 1;
        i_mode <= m;
        {i_bottom_edge, i_right_edge, i_top_edge, i_left_edge} <= box;
        i_score <= s;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(m, box, s);
        @(negedge i_clk);
        i_valid <= 0;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [8:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    // let all results drain, then allow for a box still in the iou loop
    task automatic drain();
        while (sb.frame_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // small random box, often near the last one so matches happen
    function automatic logic [63:0] rand_box(bit near);
        logic [15:0] x0, y0, w, h;
        if (near && cur_box != 0) begin
            x0 = cur_box[15:0] + 16'($urandom_range(0, 8));
            y0 = cur_box[31:16] + 16'($urandom_range(0, 8));
            w = cur_box[47:32] - cur_box[15:0];
            h = cur_box[63:48] - cur_box[31:16];
        end else begin
            x0 = 16'($urandom_range(0, 2000));
            y0 = 16'($urandom_range(0, 2000));
            w = 16'($urandom_range(0, 200));
            h = 16'($urandom_range(0, 200));
        end
        if ($urandom_range(0, 15) == 0) return {16'($urandom), 16'($urandom),
                                                16'($urandom), 16'($urandom)};
        return {y0 + h, x0 + w, y0, x0};
    endfunction

    function automatic logic signed [7:0] rand_score();
        case ($urandom_range(0, 9))
            0: return -8'sd1;
            1: return 8'($urandom);
            2: return 8'($urandom_range(51, 100));
            default: return 8'($urandom_range(0, 50));
        endcase
    endfunction

    initial begin
        logic [63:0] b;
        int nb;
        sb = new();
        quiet = 0;
        cur_box = 0;
        i_rst_n = 0;
        i_valid = 0;
        i_mode = iwt_pkg::MODE_BOX;
        i_left_edge = 0;
        i_top_edge = 0;
        i_right_edge = 0;
        i_bottom_edge = 0;
        i_score = 0;
        i_cfg_valid = 0;
        i_cfg_index = iwt_pkg::CFG_CONF;
        i_cfg_data = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed: extremes, each mode, degenerate and inverted boxes
        b = {16'd100, 16'd100, 16'd0, 16'd0};
        send_item(iwt_pkg::MODE_BOX, b, 8'sd0);
        send_item(iwt_pkg::MODE_BOX, 64'hFFFF_FFFF_FFFF_FFFF, 8'sd50);
        send_item(iwt_pkg::MODE_BOX, 64'h0, -8'sd1);
        send_item(iwt_pkg::MODE_BOX, b, -8'sd128);
        send_item(iwt_pkg::MODE_BOX, b, 8'sd127);
        send_item(iwt_pkg::MODE_BOX, {16'd0, 16'd0, 16'd50, 16'd50}, 8'sd10);
        send_item(iwt_pkg::MODE_NONE, b, 8'sd0);
        send_item(iwt_pkg::MODE_FRAME, 64'h0, 8'sd0);
        for (int f = 0; f < 5; f++) begin
            send_item(iwt_pkg::MODE_BOX, b, 8'sd5);
            send_item(iwt_pkg::MODE_BOX, {16'd300, 16'd300, 16'd200, 16'd200}, 8'sd5);
            send_item(iwt_pkg::MODE_FRAME, 64'h0, 8'sd0);
        end
        send_item(iwt_pkg::MODE_BOX, b, 8'sd5);
        send_item(iwt_pkg::MODE_FRAME, 64'h0, 8'sd0);
        send_item(iwt_pkg::MODE_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF, 8'sd0);
        drain();

        // overflow: more than sixteen boxes in a frame, after a zero overlap threshold is set
        write_reg(iwt_pkg::CFG_CONF, 9'd100);
        write_reg(iwt_pkg::CFG_PERSIST, 9'd255);
        write_reg(iwt_pkg::CFG_OVERLAP, 9'd0);
        write_reg(CfgUnused, 9'h1FF);
        for (int k = 0; k < 18; k++) send_item(iwt_pkg::MODE_BOX, rand_box(0), 8'sd1);
        send_item(iwt_pkg::MODE_FRAME, 64'h0, 8'sd0);
        drain();

        // random phases under several settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(iwt_pkg::CFG_CONF, 9'd50);
                    write_reg(iwt_pkg::CFG_PERSIST, 9'd5);
                    write_reg(iwt_pkg::CFG_OVERLAP, 9'd128);
                end
                1: begin
                    write_reg(iwt_pkg::CFG_CONF, 9'd0);
                    write_reg(iwt_pkg::CFG_PERSIST, 9'd1);
                    write_reg(iwt_pkg::CFG_OVERLAP, 9'd256);
                end
                2: begin
                    write_reg(iwt_pkg::CFG_PERSIST, 9'd0);
                    write_reg(iwt_pkg::CFG_CONF, 9'd127);
                end
                3: begin
                    write_reg(iwt_pkg::CFG_CONF, 9'd100);
                    write_reg(iwt_pkg::CFG_PERSIST, 9'd3);
                    write_reg(iwt_pkg::CFG_OVERLAP, 9'd64);
                end
                4: begin
                    write_reg(iwt_pkg::CFG_PERSIST, 9'd255);
                    write_reg(iwt_pkg::CFG_OVERLAP, 9'd200);
                end
                default: begin
                    write_reg(iwt_pkg::CFG_CONF, 9'd60);
                    write_reg(iwt_pkg::CFG_PERSIST, 9'd4);
                    write_reg(iwt_pkg::CFG_OVERLAP, 9'd100);
                    quiet = 1;
                end
            endcase
            for (int f = 0; f < 25; f++) begin
                nb = $urandom_range(0, 6);
                for (int k = 0; k < nb; k++) begin
                    b = rand_box($urandom_range(0, 3) != 0);
                    if (k == 0) cur_box = b;
                    send_item(iwt_pkg::MODE_BOX, b, rand_score());
                end
                case ($urandom_range(0, 19))
                    0: send_item(iwt_pkg::MODE_CLEAR, rand_box(0), rand_score());
                    1: send_item(iwt_pkg::MODE_NONE, rand_box(0), rand_score());
                    default: ;
                endcase
                send_item(iwt_pkg::MODE_FRAME, rand_box(0), rand_score());
                if (sb.heavy && $urandom_range(0, 3) == 0)
                    send_item(iwt_pkg::MODE_CLEAR, 64'h0, 8'sd0);
            end
            drain();
        end

        if (sb.mismatches == 0 && sb.frame_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
src/iwt_pkg.sv
src/iwt_iou_unit.sv
src/iou_weak_target_tracker.sv
tb/tb_iou_weak_target_tracker.sv
